// ===== design/rpt_pkg.sv =====
`default_nettype none

package rpt_pkg;

  // token codes on the result channel
  typedef enum logic [3:0] {
    TK_NORMAL   = 4'd0,
    TK_DOT      = 4'd1,
    TK_QUEST    = 4'd2,
    TK_PLUS     = 4'd3,
    TK_STAR     = 4'd4,
    TK_LB       = 4'd5,
    TK_RB       = 4'd6,
    TK_DASH     = 4'd7,
    TK_LPAR     = 4'd8,
    TK_RPAR     = 4'd9,
    TK_BAR      = 4'd10,
    TK_WORD     = 4'd11,
    TK_NONWORD  = 4'd12,
    TK_EOL      = 4'd13,
    TK_ENDERR   = 4'd14,
    TK_CLASSERR = 4'd15
  } tk_e;

  // pattern characters with a meaning of their own
  localparam logic [7:0] CH_ESC    = 8'h2F; // '/'
  localparam logic [7:0] CH_LB     = 8'h5B; // '['
  localparam logic [7:0] CH_RB     = 8'h5D; // ']'
  localparam logic [7:0] CH_DASH   = 8'h2D; // '-'
  localparam logic [7:0] CH_LPAR   = 8'h28; // '('
  localparam logic [7:0] CH_RPAR   = 8'h29; // ')'
  localparam logic [7:0] CH_BAR    = 8'h7C; // '|'
  localparam logic [7:0] CH_WORD   = 8'h77; // 'w'
  localparam logic [7:0] CH_NWORD  = 8'h57; // 'W'
  localparam logic [7:0] CH_DOT    = 8'h2E; // '.'
  localparam logic [7:0] CH_QUEST  = 8'h3F; // '?'
  localparam logic [7:0] CH_PLUS   = 8'h2B; // '+'
  localparam logic [7:0] CH_STAR   = 8'h2A; // '*'
  localparam logic [7:0] CH_NUL    = 8'h00;

  // input kind codes
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  // result queue sizing: room for one item in flight plus one being accepted
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned MAX_RES    = 2;
  localparam int unsigned ACCEPT_MAX = FIFO_DEPTH - MAX_RES;

  // one result item
  typedef struct packed {
    tk_e        token;
    logic [7:0] literal;
    logic       last;
  } rpt_res_t;

  // results of one input item, pushed into the queue together
  typedef struct packed {
    logic [1:0] num;
    rpt_res_t   first;
    rpt_res_t   second;
  } rpt_push_t;

endpackage

`default_nettype wire

// ===== design/rpt_lexer.sv =====
`default_nettype none

module rpt_lexer
  import rpt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic       kind_i,
  input  wire logic [7:0] ch_i,
  output rpt_push_t       push_o
);

  logic       s1_valid_q;
  logic       kind_q;
  logic [7:0] ch_q;
  logic       in_class_q, in_class_d;
  logic       esc_q, esc_d;

  logic [1:0] num;
  tk_e        tok0, tok1;
  logic [7:0] lit0, lit1;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      kind_q <= kind_i;
      ch_q   <= ch_i;
    end
  end

  // lexer flags, advanced once per registered item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_class_q <= 1'b0;
      esc_q      <= 1'b0;
    end else if (s1_valid_q) begin
      in_class_q <= in_class_d;
      esc_q      <= esc_d;
    end
  end

  // token decode for one item
  always_comb begin
    num        = 2'd1;
    tok0       = TK_NORMAL;
    lit0       = 8'h00;
    tok1       = TK_NORMAL;
    lit1       = 8'h00;
    in_class_d = in_class_q;
    esc_d      = esc_q;
    if (kind_q == KIND_EOL) begin
      // end of line drops both flags; a dangling escape reports first
      in_class_d = 1'b0;
      esc_d      = 1'b0;
      if (esc_q) begin
        num  = 2'd2;
        tok0 = in_class_q ? TK_CLASSERR : TK_ENDERR;
        tok1 = TK_EOL;
      end else begin
        tok0 = TK_EOL;
      end
    end else if (esc_q) begin
      esc_d = 1'b0;
      if (ch_q == CH_NUL) begin
        // premature end after an escape
        tok0 = in_class_q ? TK_CLASSERR : TK_ENDERR;
      end else if (in_class_q) begin
        if (ch_q inside {CH_DASH, CH_RB, CH_ESC}) begin
          lit0 = ch_q;
        end else begin
          num  = 2'd2;
          lit0 = CH_ESC;
          lit1 = ch_q;
        end
      end else begin
        case (ch_q)
          CH_LPAR:  tok0 = TK_LPAR;
          CH_RPAR:  tok0 = TK_RPAR;
          CH_BAR:   tok0 = TK_BAR;
          CH_WORD:  tok0 = TK_WORD;
          CH_NWORD: tok0 = TK_NONWORD;
          default: begin
            if (ch_q inside {CH_DOT, CH_QUEST, CH_PLUS, CH_STAR, CH_LB, CH_RB, CH_ESC})
            begin
              lit0 = ch_q;
            end else begin
              num  = 2'd2;
              lit0 = CH_ESC;
              lit1 = ch_q;
            end
          end
        endcase
      end
    end else if (ch_q == CH_ESC) begin
      num   = 2'd0;
      esc_d = 1'b1;
    end else if (in_class_q) begin
      case (ch_q)
        CH_RB: begin
          tok0       = TK_RB;
          in_class_d = 1'b0;
        end
        CH_DASH: tok0 = TK_DASH;
        CH_NUL:  tok0 = TK_CLASSERR;
        default: lit0 = ch_q;
      endcase
    end else begin
      case (ch_q)
        CH_DOT:   tok0 = TK_DOT;
        CH_QUEST: tok0 = TK_QUEST;
        CH_PLUS:  tok0 = TK_PLUS;
        CH_STAR:  tok0 = TK_STAR;
        CH_LB: begin
          tok0       = TK_LB;
          in_class_d = 1'b1;
        end
        default:  lit0 = ch_q;
      endcase
    end
  end

  // results handed to the queue
  always_comb begin
    push_o.num            = s1_valid_q ? num : 2'd0;
    push_o.first.token    = tok0;
    push_o.first.literal  = lit0;
    push_o.first.last     = (num == 2'd1);
    push_o.second.token   = tok1;
    push_o.second.literal = lit1;
    push_o.second.last    = 1'b1;
  end

  // end of line leaves the lexer in its reset state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && kind_q == KIND_EOL |=> !in_class_q && !esc_q)
    else $error("flags not cleared after end of line");

  // flags only move when an item is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |=> $stable(in_class_q) && $stable(esc_q))
    else $error("lexer flags changed without an item");

  // an escape character by itself yields no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && push_o.num == 2'd0 |=> esc_q)
    else $error("silent item did not leave an escape pending");

endmodule

`default_nettype wire

// ===== design/rpt_result_fifo.sv =====
`default_nettype none

module rpt_result_fifo
  import rpt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rpt_push_t        push_i,
  input  wire logic             pop_i,
  output logic      [CNT_W-1:0] level_o,
  output logic                  valid_o,
  output rpt_res_t              head_o
);

  rpt_res_t               mem_q [FIFO_DEPTH];
  logic     [PTR_W-1:0]   wr_q, wr_d;
  logic     [PTR_W-1:0]   rd_q, rd_d;
  logic     [CNT_W-1:0]   cnt_q, cnt_d;
  logic     [PTR_W-1:0]   wr_next;
  logic                   pop;

  assign pop     = pop_i && (cnt_q != '0);
  assign wr_next = wr_q + PTR_W'(1);

  // pointer and fill level update
  always_comb begin
    wr_d  = wr_q + PTR_W'(push_i.num);
    rd_d  = pop ? rd_q + PTR_W'(1) : rd_q;
    cnt_d = cnt_q + CNT_W'(push_i.num) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // result storage, up to two writes per cycle
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  assign level_o = cnt_q;
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  // fill level never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // a push always finds room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cnt_q} + {2'b00, push_i.num} <= (CNT_W + 1)'(FIFO_DEPTH) + (CNT_W + 1)'(pop))
    else $error("push into a full result queue");

  // level tracks pushes and pops
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q == $past(cnt_q) + CNT_W'($past(push_i.num)) - CNT_W'($past(pop)))
    else $error("result queue level out of step");

endmodule

`default_nettype wire

// ===== design/regex_pattern_tokenizer_core.sv =====
`default_nettype none

// Regular-expression pattern lexer. Each input item is one pattern byte
// (kind 0) or an end-of-line mark (kind 1); '/' is the escape character.
// An item gives zero, one or two result items (token, literal, last), with
// last set on the final result of each input item. Items pass an input
// register and a combinational decode into a four-entry result queue; the
// first result reaches the output after the input register and the queue.
// The block takes one input item per cycle while each gives at most one
// result and out_stall_i is low; the output port moves one result per cycle
// while not stalled. Input stall rises when the queue, counting the item in
// the decode stage, could not hold two more results.

module regex_pattern_tokenizer_core
  import rpt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       kind_i,
  input  wire logic [7:0] ch_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic      [3:0] token_o,
  output logic      [7:0] literal_o,
  output logic            last_o
);

  rpt_push_t              push;
  rpt_res_t               head;
  logic     [CNT_W-1:0]   level;
  logic                   in_accept;
  logic                   out_pop;
  logic     [CNT_W:0]     committed;

  // results already queued plus those of the item in decode
  assign committed  = {1'b0, level} + (CNT_W + 1)'(push.num);
  assign in_stall_o = committed > (CNT_W + 1)'(ACCEPT_MAX);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_pop    = out_valid_o && !out_stall_i;

  rpt_lexer u_lexer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .kind_i   (kind_i),
    .ch_i     (ch_i),
    .push_o   (push)
  );

  rpt_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_pop),
    .level_o (level),
    .valid_o (out_valid_o),
    .head_o  (head)
  );

  // output fields straight from the queue head
  assign token_o   = head.token;
  assign literal_o = head.literal;
  assign last_o    = head.last;

endmodule

`default_nettype wire
